@@ hw/rtl/b64d_pkg.sv @@
// b64d_pkg: shared types, constants and symbol/byte helpers for the base64 decoder.
// Used by b64d_front, b64d_queue, b64d_back and base64_stream_decoder. No dependencies.
package b64d_pkg;

	typedef logic [5:0] sym_t;

	// One decode job: the symbols that its bytes are built from, plus framing.
	typedef struct packed {
		sym_t       a;
		sym_t       b;
		sym_t       c;
		sym_t       d;
		logic [1:0] last_idx;   // index of the final beat of this job (0..2)
		logic       bare;       // end marker only, no decoded byte
		logic       eot;        // job closes the string
	} job_t;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [1:0] GROUP_FULL = 2'd3;
	localparam logic [1:0] BEAT_0 = 2'd0;
	localparam logic [1:0] BEAT_1 = 2'd1;
	localparam logic [1:0] BEAT_2 = 2'd2;

	localparam logic [5:0] MASK_HI2 = 6'h30;
	localparam logic [5:0] MASK_LO4 = 6'h0F;
	localparam logic [5:0] MASK_MID4 = 6'h3C;
	localparam logic [5:0] MASK_LO2 = 6'h03;

	// Returns {is_symbol, value}.
	function automatic logic [6:0] sym_decode(input logic [7:0] ch);
		logic [7:0] v;
		logic       ok;
		v  = 8'd0;
		ok = 1'b1;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			v = ch - 8'h41;
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			v = ch - 8'h47;
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			v = ch + 8'h04;
		end else if (ch == 8'h2B) begin
			v = 8'd62;
		end else if (ch == 8'h2F) begin
			v = 8'd63;
		end else begin
			ok = 1'b0;
		end
		return {ok, v[5:0]};
	endfunction

	function automatic logic [7:0] make_byte0(input sym_t a, input sym_t b);
		logic [5:0] t;
		t = b & MASK_HI2;
		return {a, t[5:4]};
	endfunction

	function automatic logic [7:0] make_byte1(input sym_t b, input sym_t c);
		logic [5:0] t;
		logic [5:0] u;
		t = b & MASK_LO4;
		u = c & MASK_MID4;
		return {t[3:0], u[5:2]};
	endfunction

	function automatic logic [7:0] make_byte2(input sym_t c, input sym_t d);
		logic [5:0] t;
		t = c & MASK_LO2;
		return {t[1:0], d};
	endfunction

endpackage

@@ hw/rtl/b64d_front.sv @@
// b64d_front: accepts characters, classifies them, keeps the partial group and emits jobs.
// Depends on b64d_pkg.
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,        // input beat accepted this cycle
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	output logic       push,
	output job_t       job
);

	sym_t       store_q [3];
	logic [1:0] count_q;
	logic       pad_q;

	logic [6:0] dec;
	logic       is_pad;
	logic       take;
	logic       group;
	sym_t       store_n [3];
	logic [1:0] count_n;

	always_comb begin
		dec    = sym_decode(char_code);
		is_pad = !pad_q && (char_code == PAD_CHAR);
		take   = !pad_q && !is_pad && dec[6];
		group  = take && (count_q == GROUP_FULL);

		for (int i = 0; i < 3; i++) begin
			store_n[i] = (take && count_q == 2'(i)) ? dec[5:0] : store_q[i];
		end
		count_n = group ? 2'd0 : (take ? count_q + 2'd1 : count_q);

		job = '0;
		job.eot = end_of_text;
		if (group) begin
			job.a        = store_q[0];
			job.b        = store_q[1];
			job.c        = store_q[2];
			job.d        = dec[5:0];
			job.last_idx = BEAT_2;
		end else begin
			// flush of a partial group, padded with zero symbols
			job.a = (count_n > 2'd0) ? store_n[0] : '0;
			job.b = (count_n > 2'd1) ? store_n[1] : '0;
			job.c = (count_n > 2'd2) ? store_n[2] : '0;
			job.bare     = (count_n == 2'd0);
			job.last_idx = (count_n == GROUP_FULL) ? BEAT_1 : BEAT_0;
		end
		push = fire && (group || end_of_text);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pad_q   <= 1'b0;
			for (int i = 0; i < 3; i++) store_q[i] <= '0;
		end else if (fire) begin
			if (end_of_text) begin
				count_q <= '0;
				pad_q   <= 1'b0;
				for (int i = 0; i < 3; i++) store_q[i] <= '0;
			end else begin
				count_q <= count_n;
				if (is_pad) pad_q <= 1'b1;
				for (int i = 0; i < 3; i++) store_q[i] <= store_n[i];
			end
		end
	end

endmodule

@@ hw/rtl/b64d_queue.sv @@
// b64d_queue: small job FIFO between the front and back parts.
// Depends on b64d_pkg.
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic not_empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CW'(DEPTH));
	assign head      = mem_q[rd_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= next_ptr(wr_q);
			if (pop) rd_q <= next_ptr(rd_q);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

@@ hw/rtl/b64d_back.sv @@
// b64d_back: walks the head job one beat per cycle if out_ready; forms decoded bytes.
// Depends on b64d_pkg.
module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       have_job,
	input  logic       out_ready,
	output logic       pop,
	output logic       out_valid,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       last_of_item,
	output logic       end_of_output
);

	logic [1:0] idx_q;
	logic       fire;
	logic       at_last;

	always_comb begin
		case (idx_q)
			BEAT_0: data_byte = make_byte0(head.a, head.b);
			BEAT_1: data_byte = make_byte1(head.b, head.c);
			BEAT_2: data_byte = make_byte2(head.c, head.d);
			default: data_byte = '0;
		endcase
		at_last       = (idx_q == head.last_idx);
		out_valid     = have_job;
		byte_valid    = !head.bare;
		last_of_item  = at_last;
		end_of_output = at_last && head.eot;
		fire          = have_job && out_ready;
		pop           = fire && at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= BEAT_0;
		end else if (pop) begin
			idx_q <= BEAT_0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

@@ hw/rtl/base64_stream_decoder.sv @@
// base64_stream_decoder: top level; front classifier, job queue and byte sequencer.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
// Throughput: one character beat per cycle while the queue is not full;
// output runs one byte beat per cycle while out_ready is high.
// Reset (arst_n low, async): clears group state, pad flag, queue and beat index.
module base64_stream_decoder
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// character channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	// byte channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       last_of_item,
	output logic       end_of_output
);

	// Front: every character beat is taken while the queue has room. Skipped
	// characters and those after '=' only touch state; a completed group or
	// the end mark produces one job (up to three output beats).
	// Back: drains the head job one beat a cycle while out_ready is high; a
	// full group gives three beats while the front keeps taking characters into
	// the queue. Sustained input rate is bounded by output: 3 beats per 4
	// symbols on average, so one char per cycle keeps up on typical streams.

	logic q_full;
	logic q_has;
	logic push;
	logic pop;
	logic in_fire;
	job_t new_job;
	job_t head_job;

	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;

	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.push        (push),
		.job         (new_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (new_job),
		.pop       (pop),
		.head      (head_job),
		.not_empty (q_has),
		.full      (q_full)
	);

	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head_job),
		.have_job      (q_has),
		.out_ready     (out_ready),
		.pop           (pop),
		.out_valid     (out_valid),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.last_of_item  (last_of_item),
		.end_of_output (end_of_output)
	);

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for base64_stream_decoder; directed table, then random strings.
// Depends on b64d_pkg (PAD_CHAR, GROUP_FULL, sym_t) and the decoder RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b64d_pkg::*;

	// One beat on the byte channel, as the decoder should present it.
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       eoo;
	} byte_beat_t;

	// One row of the directed table. When typed is set, want is the single beat
	// the row must produce; otherwise the predictor supplies the expectation.
	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		logic       typed;
		byte_beat_t want;
	} stim_row_t;

	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	localparam byte_beat_t NO_BEAT  = '0;
	localparam byte_beat_t END_ONLY = '{8'h00, 1'b0, 1'b1, 1'b1};

	// Directed table. Typed rows are those whose result is obvious: a lone
	// character right after the previous string closed.
	localparam int PLAN_LEN = 24;
	localparam stim_row_t PLAN [0:PLAN_LEN-1] = '{
		'{8'h3D, 1'b1, 1'b1, END_ONLY},                   // pad alone: bare end
		'{8'h41, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}}, // lowest symbol, one held
		'{8'h2F, 1'b1, 1'b1, '{8'hFC, 1'b1, 1'b1, 1'b1}}, // highest symbol, one held
		'{8'h00, 1'b1, 1'b1, END_ONLY},                   // junk, lowest code
		'{8'hFF, 1'b1, 1'b1, END_ONLY},                   // junk, highest code
		// full group closing the string: third byte carries end_of_output
		'{8'h2F, 1'b0, 1'b0, NO_BEAT},
		'{8'h2F, 1'b0, 1'b0, NO_BEAT},
		'{8'h2F, 1'b0, 1'b0, NO_BEAT},
		'{8'h2F, 1'b1, 1'b0, NO_BEAT},
		// class edges, junk neighbors of the letter ranges interleaved
		'{8'h5A, 1'b0, 1'b0, NO_BEAT},                    // 'Z'
		'{8'h40, 1'b0, 1'b0, NO_BEAT},                    // '@'
		'{8'h61, 1'b0, 1'b0, NO_BEAT},                    // 'a'
		'{8'h5B, 1'b0, 1'b0, NO_BEAT},                    // '['
		'{8'h30, 1'b0, 1'b0, NO_BEAT},                    // '0'
		'{8'h2B, 1'b0, 1'b0, NO_BEAT},                    // '+' completes group
		'{8'h7A, 1'b0, 1'b0, NO_BEAT},                    // 'z'
		'{8'h60, 1'b0, 1'b0, NO_BEAT},                    // '`'
		'{8'h39, 1'b0, 1'b0, NO_BEAT},                    // '9'
		'{8'h3D, 1'b0, 1'b0, NO_BEAT},                    // pad stops decoding
		'{8'h41, 1'b0, 1'b0, NO_BEAT},                    // symbol after pad: ignored
		'{8'h7B, 1'b1, 1'b0, NO_BEAT},                    // end on junk, two held
		// three held at end: two bytes
		'{8'h54, 1'b0, 1'b0, NO_BEAT},
		'{8'h57, 1'b0, 1'b0, NO_BEAT},
		'{8'h46, 1'b1, 1'b0, NO_BEAT}
	};

	localparam int RANDOM_ITEMS = 436;

	bit         clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last_of_item;
	logic       end_of_output;

	// Decoder state as the predictor tracks it.
	sym_t       held_sym [3] = '{default: '0};
	logic [1:0] held_cnt = '0;
	logic       pad_flag = 1'b0;

	// Beats caused by the character just accepted.
	byte_beat_t step_beats [3];
	int         step_n;

	// Beats still owed by the decoder, oldest first.
	byte_beat_t byte_q [$];

	// The row currently on the character channel.
	logic       row_typed = 1'b0;
	byte_beat_t row_want = '0;

	bit          calm = 1'b0;   // no idling on either side while set
	int unsigned hold_cnt = 0;
	int          mismatches = 0;

	base64_stream_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.last_of_item (last_of_item),
		.end_of_output(end_of_output)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// {is_symbol, value}, found by searching the alphabet string.
	function automatic logic [6:0] symbol_of(input logic [7:0] ch);
		for (int i = 0; i < 64; i++) begin
			if (ALPHABET[i] == ch) return {1'b1, 6'(i)};
		end
		return 7'd0;
	endfunction

	function automatic void push_beat(input logic [7:0] b, input logic v);
		step_beats[step_n] = '{b, v, 1'b0, 1'b0};
		step_n++;
	endfunction

	// Advances the decoder state by one character and fills step_beats.
	// The four symbols of a group form 24 bits; bytes are its three octets,
	// most significant first. Missing symbols of a partial group are zero.
	function automatic void predict_char(input logic [7:0] ch, input logic eot);
		logic [6:0]  hit;
		logic [23:0] grp;
		step_n = 0;
		if (!pad_flag) begin
			hit = symbol_of(ch);
			if (ch == PAD_CHAR) begin
				pad_flag = 1'b1;
			end else if (hit[6]) begin
				if (held_cnt == GROUP_FULL) begin
					grp = {held_sym[0], held_sym[1], held_sym[2], hit[5:0]};
					push_beat(grp[23:16], 1'b1);
					push_beat(grp[15:8], 1'b1);
					push_beat(grp[7:0], 1'b1);
					held_cnt = '0;
				end else begin
					held_sym[held_cnt] = hit[5:0];
					held_cnt = held_cnt + 2'd1;
				end
			end
		end
		if (eot) begin
			grp = {held_sym[0],
				(held_cnt > 2'd1) ? held_sym[1] : 6'd0,
				(held_cnt > 2'd2) ? held_sym[2] : 6'd0,
				6'd0};
			// one or two held symbols give one byte, three give two
			if (held_cnt != 2'd0) push_beat(grp[23:16], 1'b1);
			if (held_cnt == GROUP_FULL) push_beat(grp[15:8], 1'b1);
			if (step_n == 0) push_beat(8'h00, 1'b0);
			step_beats[step_n-1].eoo = 1'b1;
			held_sym = '{default: '0};
			held_cnt = '0;
			pad_flag = 1'b0;
		end
		if (step_n != 0) step_beats[step_n-1].last = 1'b1;
	endfunction

	// Mostly back-to-back, often a short gap, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Presents one character beat and returns at the edge that accepts it.
	task automatic send_char(input logic [7:0] ch, input logic eot, input logic typed,
			input byte_beat_t want);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_code   = ch;
		end_of_text = eot;
		row_typed   = typed;
		row_want    = want;
		in_valid    = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Sender backs off until every owed beat has come out.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (byte_q.size() != 0) @(negedge clk);
	endtask

	// Byte channel back-pressure: ready for a beat, then a random stall.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 1'b0;
		end else if (hold_cnt != 0) begin
			out_ready = 1'b0;
			hold_cnt--;
		end else begin
			out_ready = 1'b1;
			hold_cnt  = pick_gap();
		end
	end

	// Prediction and checking share one process so that a beat pushed and a
	// beat popped at the same edge are handled in a fixed order.
	always @(posedge clk) begin : scoreboard
		byte_beat_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_char(char_code, end_of_text);
				if (row_typed) begin
					byte_q = {byte_q, row_want};
				end else begin
					for (int i = 0; i < step_n; i++) byte_q = {byte_q, step_beats[i]};
				end
			end
			if (out_valid && out_ready) begin
				if (byte_q.size() == 0) begin
					$error("unexpected beat: data_byte %02h byte_valid %b last %b eoo %b",
						data_byte, byte_valid, last_of_item, end_of_output);
					mismatches++;
				end else begin
					want = byte_q.pop_front();
					if (data_byte !== want.data) begin
						$error("data_byte: expected %02h, got %02h", want.data, data_byte);
						mismatches++;
					end
					if (byte_valid !== want.valid) begin
						$error("byte_valid: expected %b, got %b", want.valid, byte_valid);
						mismatches++;
					end
					if (last_of_item !== want.last) begin
						$error("last_of_item: expected %b, got %b", want.last, last_of_item);
						mismatches++;
					end
					if (end_of_output !== want.eoo) begin
						$error("end_of_output: expected %b, got %b", want.eoo, end_of_output);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		logic [7:0] text [$];
		int         live_items;
		int         str_idx;
		int         kind;
		int         nsym;
		live_items = 0;
		str_idx    = 0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (PLAN[i]) send_char(PLAN[i].ch, PLAN[i].eot, PLAN[i].typed, PLAN[i].want);
		drain();

		// Random strings. Most are well-formed base64 with random content,
		// sometimes with junk sprinkled in or trailing the pad; the rest are
		// arbitrary bytes. Every character beat sent is counted.
		while (live_items < RANDOM_ITEMS) begin
			text.delete();
			calm = (str_idx >= 20 && str_idx < 35);
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				nsym = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
					: $urandom_range(0, 12);
				repeat (nsym) begin
					if ($urandom_range(0, 9) == 0) text = {text, 8'($urandom_range(0, 255))};
					text = {text, 8'(ALPHABET[$urandom_range(0, 63)])};
				end
				if ($urandom_range(0, 9) < 7) begin
					if (nsym % 4 == 2) begin
						text = {text, PAD_CHAR};
						text = {text, PAD_CHAR};
					end else if (nsym % 4 == 3) begin
						text = {text, PAD_CHAR};
					end
					if ($urandom_range(0, 3) == 0) text = {text, 8'($urandom_range(0, 255))};
				end
			end else begin
				repeat ($urandom_range(1, 8)) text = {text, 8'($urandom_range(0, 255))};
			end
			if (text.size() == 0) text = {text, 8'($urandom_range(0, 255))};

			foreach (text[i]) begin
				live_items++;
				send_char(text[i], i == text.size() - 1, 1'b0, NO_BEAT);
			end
			if ($urandom_range(0, 24) == 0) drain();
			str_idx++;
		end

		calm = 1'b0;
		drain();
		// idle on to catch any stray beat
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// ~500 items, up to three beats each, each beat behind a random stall, plus
	// sender gaps: well inside the timeout below.
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
